// ===== sv/qte_pkg.sv =====
// Shared widths, beat types and constant tables for the quaternion to Euler angle pipeline.
package qte_pkg;

  // Number of vectoring CORDIC cells in each angle lane.
  localparam int CORDIC_STAGES = 16;
  // One square-root cell per result bit of floor(sqrt(2^56 - s^2)).
  localparam int SQRT_STAGES   = 29;

  localparam int CW     = 36;  // CORDIC abscissa and ordinate width
  localparam int AW     = 27;  // angle accumulator width, degrees with 16 fraction bits
  localparam int REM_W  = 60;  // square-root remainder width
  localparam int ROOT_W = 29;  // square-root result width
  localparam int S_W    = 30;  // clamped arcsine argument width
  localparam int IDX_W  = 5;   // stage or bit index width

  localparam logic signed [AW-1:0] DEG180 = AW'(180 * 65536);
  localparam logic signed [AW:0]   LIM_XZ = (AW + 1)'(23040);
  localparam logic signed [AW:0]   LIM_Y  = (AW + 1)'(11520);

  // One CORDIC lane beat: vector, accumulated angle and the both-zero mark.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
  } lane_t;

  // One square-root beat, with the arcsine ordinate travelling alongside.
  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
    logic signed [S_W-1:0] s;
  } sqrt_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest.
  function automatic logic signed [AW-1:0] atan_tab(input logic [IDX_W-1:0] i);
    logic signed [AW-1:0] v;
    case (i)
      5'd0:    v = AW'(2949120);
      5'd1:    v = AW'(1740967);
      5'd2:    v = AW'(919879);
      5'd3:    v = AW'(466945);
      5'd4:    v = AW'(234379);
      5'd5:    v = AW'(117304);
      5'd6:    v = AW'(58666);
      5'd7:    v = AW'(29335);
      5'd8:    v = AW'(14668);
      5'd9:    v = AW'(7334);
      5'd10:   v = AW'(3667);
      5'd11:   v = AW'(1833);
      5'd12:   v = AW'(917);
      5'd13:   v = AW'(458);
      5'd14:   v = AW'(229);
      5'd15:   v = AW'(115);
      5'd16:   v = AW'(57);
      5'd17:   v = AW'(29);
      5'd18:   v = AW'(14);
      5'd19:   v = AW'(7);
      5'd20:   v = AW'(4);
      5'd21:   v = AW'(2);
      5'd22:   v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Rounds to Q9.7 degrees and saturates to +-lim; gives zero where the zero mark is set.
  function automatic logic signed [15:0] to_q97(input logic signed [AW-1:0] acc,
                                                input logic zero,
                                                input logic signed [AW:0] lim);
    logic signed [AW:0] t;
    logic signed [AW:0] r;
    t = (AW + 1)'(acc) + (AW + 1)'(256);
    r = t >>> 9;
    if (zero) begin
      r = '0;
    end else if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r[15:0];
  endfunction

endpackage

// ===== sv/qte_front.sv =====
// Front end: quaternion products, atan2 operands, arcsine clamp and square-root seed.
module qte_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [15:0]    quat_w,
  input  logic signed [15:0]    quat_x,
  input  logic signed [15:0]    quat_y,
  input  logic signed [15:0]    quat_z,
  output logic                  valid,
  output qte_pkg::sqrt_t        sq,
  output qte_pkg::lane_t        lane_z,
  output qte_pkg::lane_t        lane_x,
  output logic                  clamped
);

  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

  logic v1, v2, v3;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_zw, p_yz, p_xw, p_xz, p_yw;
  logic signed [33:0] num_z, den_z, num_x, den_x;
  logic signed [33:0] s_raw;
  logic signed [qte_pkg::S_W-1:0] s_cl, s_cl3;
  logic [qte_pkg::ROOT_W-1:0] s_mag;
  logic clamp2, clamp3;
  logic [56:0] s_sq;
  qte_pkg::lane_t lz_next, lx_next, lz3, lx3;

  assign s_raw = (34'(p_yw) - 34'(p_xz)) <<< 1;

  // Sends a negative abscissa to the right half-plane, starting at +-180 degrees.
  function automatic qte_pkg::lane_t prep(input logic signed [33:0] num,
                                          input logic signed [33:0] den);
    qte_pkg::lane_t l;
    l.zero = (num == '0) && (den == '0);
    if (den < 0) begin
      l.x   = -qte_pkg::CW'(den);
      l.y   = -qte_pkg::CW'(num);
      l.acc = (num >= 0) ? qte_pkg::DEG180 : -qte_pkg::DEG180;
    end else begin
      l.x   = qte_pkg::CW'(den);
      l.y   = qte_pkg::CW'(num);
      l.acc = '0;
    end
    return l;
  endfunction

  always_comb begin
    lz_next = prep(num_z, den_z);
    lx_next = prep(num_x, den_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      valid <= v3;
    end
    p_ww <= quat_w * quat_w;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_zz <= quat_z * quat_z;
    p_xy <= quat_x * quat_y;
    p_zw <= quat_z * quat_w;
    p_yz <= quat_y * quat_z;
    p_xw <= quat_x * quat_w;
    p_xz <= quat_x * quat_z;
    p_yw <= quat_y * quat_w;

    num_z <= (34'(p_xy) + 34'(p_zw)) <<< 1;
    den_z <= 34'(p_xx) - 34'(p_yy) - 34'(p_zz) + 34'(p_ww);
    num_x <= (34'(p_yz) + 34'(p_xw)) <<< 1;
    den_x <= 34'(p_zz) + 34'(p_ww) - 34'(p_xx) - 34'(p_yy);
    if (s_raw > ONE_Q28) begin
      s_cl   <= qte_pkg::S_W'(ONE_Q28);
      s_mag  <= qte_pkg::ROOT_W'(ONE_Q28);
      clamp2 <= 1'b1;
    end else if (s_raw < -ONE_Q28) begin
      s_cl   <= -qte_pkg::S_W'(ONE_Q28);
      s_mag  <= qte_pkg::ROOT_W'(ONE_Q28);
      clamp2 <= 1'b1;
    end else begin
      s_cl   <= qte_pkg::S_W'(s_raw);
      s_mag  <= (s_raw < 0) ? qte_pkg::ROOT_W'(-s_raw) : qte_pkg::ROOT_W'(s_raw);
      clamp2 <= 1'b0;
    end

    s_sq   <= 57'(s_mag) * 57'(s_mag);
    s_cl3  <= s_cl;
    clamp3 <= clamp2;
    lz3    <= lz_next;
    lx3    <= lx_next;

    sq.rem  <= (qte_pkg::REM_W'(1) << 56) - qte_pkg::REM_W'(s_sq);
    sq.root <= '0;
    sq.s    <= s_cl3;
    clamped <= clamp3;
    lane_z  <= lz3;
    lane_x  <= lx3;
  end

endmodule

// ===== sv/qte_sqrt_cell.sv =====
// One cell of the square-root row: decides a single result bit.
module qte_sqrt_cell (
  input  logic                         clk,
  input  logic [qte_pkg::IDX_W-1:0]    bit_idx,
  input  qte_pkg::sqrt_t               d_in,
  output qte_pkg::sqrt_t               d_out
);

  logic [qte_pkg::REM_W-1:0] trial;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b).
  assign trial = (qte_pkg::REM_W'(d_in.root) << (6'(bit_idx) + 6'd1))
               + (qte_pkg::REM_W'(1) << {bit_idx, 1'b0});

  always_ff @(posedge clk) begin
    d_out.s <= d_in.s;
    if (d_in.rem >= trial) begin
      d_out.rem  <= d_in.rem - trial;
      d_out.root <= d_in.root | (qte_pkg::ROOT_W'(1) << bit_idx);
    end else begin
      d_out.rem  <= d_in.rem;
      d_out.root <= d_in.root;
    end
  end

endmodule

// ===== sv/qte_cordic_cell.sv =====
// One vectoring CORDIC cell: a single micro-rotation toward the positive axis.
module qte_cordic_cell (
  input  logic                         clk,
  input  logic [qte_pkg::IDX_W-1:0]    stage,
  input  qte_pkg::lane_t               d_in,
  output qte_pkg::lane_t               d_out
);

  logic signed [qte_pkg::CW-1:0] dx, dy;
  logic signed [qte_pkg::AW-1:0] step;

  assign dx   = d_in.x >>> stage;
  assign dy   = d_in.y >>> stage;
  assign step = qte_pkg::atan_tab(stage);

  always_ff @(posedge clk) begin
    d_out.zero <= d_in.zero;
    if (d_in.y > 0) begin
      d_out.x   <= d_in.x + dy;
      d_out.y   <= d_in.y - dx;
      d_out.acc <= d_in.acc + step;
    end else begin
      d_out.x   <= d_in.x - dy;
      d_out.y   <= d_in.y + dx;
      d_out.acc <= d_in.acc - step;
    end
  end

endmodule

// ===== sv/quaternion_to_euler_degrees.sv =====
// Top level: quaternion in, three Euler angles in Q9.7 degrees (Y in Q8.7) out, fully pipelined.
//
//   Channel   Handshake         Payload
//   input     start / busy      quat_w, quat_x, quat_y, quat_z (signed Q2.14)
//   result    done (strobe)     angle_x_deg, angle_y_deg, angle_z_deg, asin_clamped
//
// A beat is taken at every edge where start is high; busy is never raised, so one
// quaternion enters per clock cycle. Each result passes through 50 registers: four
// front-end stages, 29 square-root cells, CORDIC_STAGES (16) CORDIC cells and the
// output register. The square-root row is the longest of these parts.
// Reset (rst, synchronous) clears only the valid bits, not the data registers.
// The receiver cannot stall, so done is a one-cycle strobe per result beat.
module quaternion_to_euler_degrees (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic signed [15:0] angle_x_deg,
  output logic signed [14:0] angle_y_deg,
  output logic signed [15:0] angle_z_deg,
  output logic               asin_clamped
);

  localparam int NS  = qte_pkg::SQRT_STAGES;
  localparam int NC  = qte_pkg::CORDIC_STAGES;
  localparam int TOT = NS + NC;

  logic front_valid, front_clamped;
  qte_pkg::sqrt_t front_sq;
  qte_pkg::lane_t front_lz, front_lx;

  // The block never holds a beat off: every stage advances each cycle.
  assign busy = 1'b0;

  qte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .valid    (front_valid),
    .sq       (front_sq),
    .lane_z   (front_lz),
    .lane_x   (front_lx),
    .clamped  (front_clamped)
  );

  // The square-root row produces the arcsine abscissa, one result bit per cell,
  // most significant bit first.
  qte_pkg::sqrt_t sq_row [0:NS];
  assign sq_row[0] = front_sq;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk     (clk),
      .bit_idx (qte_pkg::IDX_W'(NS - 1 - k)),
      .d_in    (sq_row[k]),
      .d_out   (sq_row[k+1])
    );
  end

  // The two atan2 lanes wait alongside the square-root row so that all three
  // CORDIC lanes start together.
  qte_pkg::lane_t lz_dly [0:NS-1];
  qte_pkg::lane_t lx_dly [0:NS-1];

  always_ff @(posedge clk) begin
    lz_dly[0] <= front_lz;
    lx_dly[0] <= front_lx;
    for (int i = 1; i < NS; i++) begin
      lz_dly[i] <= lz_dly[i-1];
      lx_dly[i] <= lx_dly[i-1];
    end
  end

  // Valid bits and the clamp flag follow the beat through both rows.
  logic [TOT-1:0] vpipe;
  logic [TOT-1:0] cpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[TOT-2:0], front_valid};
    end
    cpipe <= {cpipe[TOT-2:0], front_clamped};
  end

  // Three CORDIC rows: Z and X are atan2 of the quaternion terms, Y is the
  // arcsine taken as atan2(s, sqrt(1 - s^2)). The abscissa of Y is never
  // negative and never zero together with s, so that lane needs no pre-rotation.
  qte_pkg::lane_t cz [0:NC];
  qte_pkg::lane_t cx [0:NC];
  qte_pkg::lane_t cy [0:NC];

  assign cz[0] = lz_dly[NS-1];
  assign cx[0] = lx_dly[NS-1];
  always_comb begin
    cy[0].x    = qte_pkg::CW'(sq_row[NS].root);
    cy[0].y    = qte_pkg::CW'(sq_row[NS].s);
    cy[0].acc  = '0;
    cy[0].zero = 1'b0;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    qte_cordic_cell u_z (
      .clk   (clk),
      .stage (qte_pkg::IDX_W'(i)),
      .d_in  (cz[i]),
      .d_out (cz[i+1])
    );
    qte_cordic_cell u_x (
      .clk   (clk),
      .stage (qte_pkg::IDX_W'(i)),
      .d_in  (cx[i]),
      .d_out (cx[i+1])
    );
    qte_cordic_cell u_y (
      .clk   (clk),
      .stage (qte_pkg::IDX_W'(i)),
      .d_in  (cy[i]),
      .d_out (cy[i+1])
    );
  end

  // Output register: round to Q9.7, saturate, and force zero where both
  // atan2 operands were zero.
  logic signed [15:0] ay_full;
  assign ay_full = qte_pkg::to_q97(cy[NC].acc, cy[NC].zero, qte_pkg::LIM_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vpipe[TOT-1];
    end
    angle_z_deg  <= qte_pkg::to_q97(cz[NC].acc, cz[NC].zero, qte_pkg::LIM_XZ);
    angle_x_deg  <= qte_pkg::to_q97(cx[NC].acc, cx[NC].zero, qte_pkg::LIM_XZ);
    angle_y_deg  <= ay_full[14:0];
    asin_clamped <= cpipe[TOT-1];
  end

endmodule
